@@ hw/rtl/line_substring_matcher_unit_defines.svh @@
// Assertion macros shared by the line substring matcher RTL.
`ifndef LINE_SUBSTRING_MATCHER_UNIT_DEFINES_SVH
`define LINE_SUBSTRING_MATCHER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define LSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Implication whose consequent is checked in the next cycle, outside reset.
`define LSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define LSM_ASSERT(lbl, prop, msg)
`define LSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/lsm_pkg.sv @@
// Types and constants of the line substring matcher.
package lsm_pkg;

  localparam int MaxPattern = 16;
  localparam int ByteW      = 8;
  localparam int LenW       = 5;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 2;
  localparam int PatW       = MaxPattern * ByteW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPatLen  = 2'd2;

  // Per-cycle control broadcast to every window cell.
  typedef struct packed {
    logic shift;  // a byte enters the window
    logic clear;  // the line closes, window goes empty
  } cell_ctrl_t;

endpackage

@@ hw/rtl/lsm_cell.sv @@
// One window cell: holds one recent byte and its filled flag, compares against one pattern byte.
module lsm_cell
  import lsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [ByteW-1:0] byte_i,      // from the newer neighbor
  input  logic             filled_i,
  input  logic [ByteW-1:0] pat_byte_i,  // pattern byte aligned to this cell
  input  logic             active_i,    // cell lies inside the pattern length
  output logic [ByteW-1:0] byte_o,
  output logic             filled_o,
  output logic             match_o      // match on the content after this shift
);

  logic [ByteW-1:0] byte_q;
  logic             filled_q, filled_d;

  always_comb begin
    filled_d = filled_q;
    if (ctrl_i.shift) begin
      filled_d = filled_i;
    end
    if (ctrl_i.clear) begin
      filled_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  // Only meaningful when a byte shifts in; the top qualifies it.
  assign match_o  = !active_i || (filled_i && (byte_i == pat_byte_i));
  assign byte_o   = byte_q;
  assign filled_o = filled_q;

endmodule

@@ hw/rtl/line_substring_matcher_unit.sv @@
// Top level of the line substring matcher: config registers, cell chain, output buffer.
//
// Usage: text arrives on the input channel one item per cycle (in_valid_i / in_stall_o),
// each item carrying text_byte_i, byte_present_i and end_of_line_i. Lines come framed:
// the item with end_of_line_i high closes the line; byte_present_i low with end_of_line_i
// high closes an empty line without adding a byte.
// For every closing item one item leaves on the output channel (out_valid_o / out_stall_i)
// with line_matched_o set when the configured pattern occurred whole inside the line.
// Results: each closing item's result is registered in the output register or the skid entry.
// Throughput: one item per cycle while in_stall_o is low. The window is a chain of 16 cells that shift
// one byte per accepted item that carries one and all compare in the same cycle, so no item waits on another.
// Output stalls: results go to an output register backed by one skid entry. in_stall_o
// rises only while the skid entry is occupied; the block keeps taking items while a
// single result waits.
// Configuration: write cfg_we_i with cfg_idx_i (0 pattern bytes 0-7, 1 pattern bytes 8-15,
// 2 pattern length) and cfg_wdata_i; writes take effect on the next accepted item.
// A pattern length above 16 acts as 16; zero matches any non-empty line.
// Reset: registers clear to zero, the window empties, no result is pending.
`include "line_substring_matcher_unit_defines.svh"

module line_substring_matcher_unit
  import lsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    text_byte_i,
  input  logic                byte_present_i,
  input  logic                end_of_line_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                line_matched_o
);

  // ---------------- configuration registers ----------------
  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [LenW-1:0]     pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPatLow:  pat_low_q  <= cfg_wdata_i;
        RegPatHigh: pat_high_q <= cfg_wdata_i;
        RegPatLen:  pat_len_q  <= cfg_wdata_i[LenW-1:0];
        default:    ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- pattern alignment ----------------
  // Cell k holds the k-th newest byte and must meet pattern byte len-1-k.
  // Reverse the pattern, then shift down by (16 - len) bytes.
  logic [LenW-1:0] len_c;
  logic [LenW-1:0] shift_bytes;
  logic [PatW-1:0] pat_all, pat_rev, pat_aligned;

  assign len_c       = (pat_len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : pat_len_q;
  assign shift_bytes = LenW'(MaxPattern) - len_c;
  assign pat_all     = {pat_high_q, pat_low_q};

  always_comb begin
    for (int m = 0; m < MaxPattern; m++) begin
      pat_rev[m*ByteW +: ByteW] = pat_all[(MaxPattern-1-m)*ByteW +: ByteW];
    end
  end

  assign pat_aligned = pat_rev >> {shift_bytes, 3'b000};

  // ---------------- handshake ----------------
  logic in_acc, out_take;
  logic out_valid_q, out_valid_d, out_data_q, out_data_d;
  logic skid_valid_q, skid_valid_d, skid_data_q, skid_data_d;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // ---------------- cell chain ----------------
  cell_ctrl_t                       ctrl;
  logic [MaxPattern-1:0][ByteW-1:0] chain_byte;
  logic [MaxPattern-1:0]            chain_filled;
  logic [MaxPattern-1:0]            cell_match;
  logic [MaxPattern-1:0]            cell_active;

  assign ctrl.shift = in_acc && byte_present_i;
  assign ctrl.clear = in_acc && end_of_line_i;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic [ByteW-1:0] byte_in;
    logic             filled_in;

    if (k == 0) begin : g_head
      assign byte_in   = text_byte_i;
      assign filled_in = 1'b1;
    end else begin : g_body
      assign byte_in   = chain_byte[k-1];
      assign filled_in = chain_filled[k-1];
    end

    assign cell_active[k] = LenW'(k) < len_c;

    lsm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (byte_in),
      .filled_i   (filled_in),
      .pat_byte_i (pat_aligned[k*ByteW +: ByteW]),
      .active_i   (cell_active[k]),
      .byte_o     (chain_byte[k]),
      .filled_o   (chain_filled[k]),
      .match_o    (cell_match[k])
    );
  end

  // ---------------- per-line match latch ----------------
  logic found_q, found_d, found_now;

  // Empty pattern: every cell inactive, so any byte hits.
  assign found_now = found_q || (byte_present_i && (&cell_match));

  always_comb begin
    found_d = found_q;
    if (in_acc) begin
      found_d = end_of_line_i ? 1'b0 : found_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  // ---------------- output register with skid entry ----------------
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // input is stalled; drain skid into output when it frees
      if (out_take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !out_take) begin
      if (ctrl.clear) begin
        skid_valid_d = 1'b1;
        skid_data_d  = found_now;
      end
    end else begin
      out_valid_d = ctrl.clear;
      out_data_d  = found_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign line_matched_o = out_data_q;

  // ---------------- assertions ----------------
  `LSM_ASSERT(a_skid_behind_out, (!skid_valid_q || out_valid_q), "skid holds item while output empty")
  `LSM_ASSERT(a_filled_prefix, ((chain_filled[MaxPattern-1:1] & ~chain_filled[MaxPattern-2:0]) == '0), "filled cells not contiguous")
  `LSM_ASSERT_NEXT(a_line_cleared, (in_acc && end_of_line_i), ((chain_filled == '0) && !found_q), "line state not cleared at line end")
  `LSM_ASSERT_NEXT(a_result_queued, (in_acc && end_of_line_i), out_valid_q, "line end produced no result")

endmodule

@@ verif/tb_line_substring_matcher_unit.sv @@
// Testbench for line_substring_matcher_unit: framed text lines, pattern search, checked per line.
module tb_line_substring_matcher_unit
  import lsm_pkg::*;
();

  localparam int QuietLimit  = 2000;  // cycles with no handshake before the run is abandoned
  localparam int DrainCycles = 4;     // margin after the last result is taken
  localparam int ReportMax   = 10;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = RegPatLow;
  logic [CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    text_byte_i    = '0;
  logic                byte_present_i = 1'b0;
  logic                end_of_line_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                line_matched_o;

  line_substring_matcher_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_line_i  (end_of_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_matched_o (line_matched_o)
  );

  // Matcher model: pattern registers, per-line window and hit latch.
  logic [CfgDataW-1:0] pat_low_q  = '0;
  logic [CfgDataW-1:0] pat_high_q = '0;
  logic [LenW-1:0]     pat_len_q  = '0;
  logic [ByteW-1:0]    window_q [MaxPattern];  // entry 0 holds the newest byte
  int unsigned         seen_q;
  bit                  found_q;
  bit                  match_flags_due [$];    // one flag per closed line, oldest first

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 46;
  int unsigned items_sent    = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_line_state();
    foreach (window_q[i]) window_q[i] = '0;
    seen_q  = 0;
    found_q = 1'b0;
  endfunction

  // Lengths above the window size behave as a full-window pattern.
  function automatic int unsigned active_len();
    return (pat_len_q > MaxPattern) ? MaxPattern : pat_len_q;
  endfunction

  function automatic logic [ByteW-1:0] pattern_byte(input int unsigned idx);
    logic [PatW-1:0] bits;
    bits = {pat_high_q, pat_low_q};
    return bits[ByteW*idx +: ByteW];
  endfunction

  function automatic void report_mismatch(input string what, input logic exp_v,
                                          input logic act_v);
    mismatches++;
    if (mismatches <= ReportMax)
      $display("mismatch: %s expected %b got %b at %0t", what, exp_v, act_v, $time);
  endfunction

  // Random idle gaps before the item; once valid is up, hold until taken.
  task automatic send_text_item(input logic [ByteW-1:0] b, input logic present,
                                input logic eol);
    int unsigned len;
    bit          hit;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    byte_present_i <= present;
    end_of_line_i  <= eol;
    do @(posedge clk_i); while (in_stall_o);
    // taken at this edge: byte is compared first, then the line may close
    if (present) begin
      for (int i = MaxPattern - 1; i > 0; i--) window_q[i] = window_q[i - 1];
      window_q[0] = b;
      if (seen_q < MaxPattern) seen_q++;
      len = active_len();
      if (len == 0) begin
        found_q = 1'b1;
      end else if (seen_q >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (window_q[len - 1 - i] != pattern_byte(i)) hit = 1'b0;
        if (hit) found_q = 1'b1;
      end
    end
    if (eol) begin
      match_flags_due.push_back(found_q);
      clear_line_state();
    end
    if (present || eol) items_sent++;
  endtask

  // Empty text gives a byte-less close; close_apart ends a non-empty line the same way.
  task automatic send_line(input logic [ByteW-1:0] text [$], input bit close_apart);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(99, 0) < 4)
        send_text_item(ByteW'($urandom_range(255, 0)), 1'b0, 1'b0);
      send_text_item(text[i], 1'b1, !close_apart && (i == text.size() - 1));
    end
    if (close_apart || text.size() == 0)
      send_text_item(ByteW'($urandom_range(255, 0)), 1'b0, 1'b1);
  endtask

  task automatic settle_matcher();
    in_valid_i <= 1'b0;
    while (match_flags_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic program_pattern(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                                 input logic [CfgDataW-1:0] len_word);
    settle_matcher();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegPatLow;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    pat_low_q    = lo;
    cfg_idx_i   <= RegPatHigh;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    pat_high_q   = hi;
    cfg_idx_i   <= RegPatLen;
    cfg_wdata_i <= len_word;
    @(posedge clk_i);
    pat_len_q    = len_word[LenW-1:0];
    cfg_we_i    <= 1'b0;
  endtask

  task automatic pick_pattern();
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    logic [ByteW-1:0]    letters [4];
    int unsigned         len;
    letters = '{8'h00, 8'h61, 8'h62, 8'hFF};
    case ($urandom_range(5, 0))
      0: begin
        lo = '0;
        hi = '0;
      end
      1: begin
        lo = '1;
        hi = '1;
      end
      2: begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      default: begin
        // tiny alphabet: repeats and self-overlap, random text hits often
        for (int i = 0; i < 8; i++) begin
          lo[ByteW*i +: ByteW] = letters[$urandom_range(3, 0)];
          hi[ByteW*i +: ByteW] = letters[$urandom_range(3, 0)];
        end
      end
    endcase
    case ($urandom_range(7, 0))
      0:       len = 0;
      1:       len = 1;
      2:       len = MaxPattern;
      3:       len = $urandom_range(31, MaxPattern + 1);
      4:       len = $urandom_range(MaxPattern, 1);
      default: len = $urandom_range(5, 2);
    endcase
    program_pattern(lo, hi, CfgDataW'(len));
  endtask

  // Reset config has an empty pattern: empty line misses, any byte hits.
  task automatic test_empty_and_noise();
    logic [ByteW-1:0] text [$];
    text = {};
    send_line(text, 1'b0);
    send_text_item(8'hA5, 1'b0, 1'b0);
    text = {8'h78};
    send_line(text, 1'b0);
  endtask

  // Zero pattern bytes against a cleared window: too few bytes must not hit.
  task automatic test_zero_bytes();
    logic [ByteW-1:0] text [$];
    program_pattern('0, '0, CfgDataW'(3));
    text = {8'h00, 8'h00};
    send_line(text, 1'b1);
    text = {8'h00, 8'h00, 8'h00};
    send_line(text, 1'b0);
  endtask

  // Length 31 acts as 16: fifteen matching bytes are one short.
  task automatic test_long_pattern();
    logic [ByteW-1:0] text [$];
    program_pattern('1, '1, CfgDataW'(31));
    text = {};
    for (int i = 0; i < MaxPattern - 1; i++) text.push_back(8'hFF);
    send_line(text, 1'b1);
  endtask

  // Mostly lines that carry the pattern or a near miss, over changing settings.
  task automatic test_random_lines(input int unsigned item_goal);
    logic [ByteW-1:0] text [$];
    int unsigned      stop_at;
    int unsigned      next_setting;
    int unsigned      n;
    int unsigned      plen;
    int unsigned      at;
    stop_at      = items_sent + item_goal;
    next_setting = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_setting) begin
        pick_pattern();
        next_setting = items_sent + $urandom_range(110, 50);
      end
      plen = active_len();
      text.delete();
      n = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(40, 1);
      for (int i = 0; i < n; i++) begin
        if (plen != 0 && $urandom_range(1, 0) == 1)
          text.push_back(pattern_byte($urandom_range(plen - 1, 0)));
        else
          text.push_back(ByteW'($urandom_range(255, 0)));
      end
      if (plen != 0 && n >= plen && $urandom_range(99, 0) < 60) begin
        at = $urandom_range(n - plen, 0);
        for (int i = 0; i < plen; i++) text[at + i] = pattern_byte(i);
        // flip one bit now and then for a near miss
        if ($urandom_range(2, 0) == 0)
          text[at + $urandom_range(plen - 1, 0)] ^= 8'h01 << $urandom_range(7, 0);
      end
      send_line(text, $urandom_range(3, 0) == 0);
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  // Each result taken is compared with the oldest closed line.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (match_flags_due.size() == 0) begin
        report_mismatch("result with no line closed", 1'bx, line_matched_o);
      end else begin
        if (line_matched_o !== match_flags_due[0])
          report_mismatch("line_matched", match_flags_due[0], line_matched_o);
        void'(match_flags_due.pop_front());
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_line_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_noise();
    test_zero_bytes();
    test_long_pattern();
    // sender gaps light, receiver stalls heavy
    test_random_lines(580);
    settle_matcher();
    send_idle_pct = 46;
    recv_idle_pct = 19;
    test_random_lines(580);
    settle_matcher();
    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(580);
    settle_matcher();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lsm_pkg.sv
hw/rtl/lsm_cell.sv
hw/rtl/line_substring_matcher_unit.sv
verif/tb_line_substring_matcher_unit.sv
